// ===== design/mpq_pkg.sv =====
package mpq_pkg;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // datapath operations
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_ACCEPT    = 4'd1;
  localparam logic [3:0] OP_UP_RD     = 4'd2;
  localparam logic [3:0] OP_UP_MOVE   = 4'd3;
  localparam logic [3:0] OP_PLACE     = 4'd4;
  localparam logic [3:0] OP_ROOT_RD   = 4'd5;
  localparam logic [3:0] OP_ROOT_TAKE = 4'd6;
  localparam logic [3:0] OP_DN_RD     = 4'd7;
  localparam logic [3:0] OP_DN_MOVE   = 4'd8;

  typedef struct packed {
    logic [3:0] op;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       fail;
    logic       at_root;
    logic       up_less;
    logic       dn_leaf;
    logic       dn_less;
  } stat_t;

endpackage

// ===== design/mpq_ctrl.sv =====
module mpq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  mpq_pkg::stat_t st,
  output mpq_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DISPATCH  = 4'd1;
  localparam logic [3:0] S_UP_RD     = 4'd2;
  localparam logic [3:0] S_UP_CMP    = 4'd3;
  localparam logic [3:0] S_ROOT_TAKE = 4'd4;
  localparam logic [3:0] S_DN_RD     = 4'd5;
  localparam logic [3:0] S_DN_CMP    = 4'd6;
  localparam logic [3:0] S_FIN       = 4'd7;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = mpq_pkg::OP_NONE;
    cmd.load_out = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = mpq_pkg::OP_ACCEPT;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (st.fail) begin
          state_nxt = S_FIN;
        end else if (st.kind == mpq_pkg::KIND_INSERT) begin
          state_nxt = S_UP_RD;
        end else if (st.kind inside {mpq_pkg::KIND_REMOVE, mpq_pkg::KIND_READ}) begin
          cmd.op    = mpq_pkg::OP_ROOT_RD;
          state_nxt = S_ROOT_TAKE;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_UP_RD: begin
        if (st.at_root) begin
          cmd.op    = mpq_pkg::OP_PLACE;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = mpq_pkg::OP_UP_RD;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (st.up_less) begin
          cmd.op    = mpq_pkg::OP_UP_MOVE;
          state_nxt = S_UP_RD;
        end else begin
          cmd.op    = mpq_pkg::OP_PLACE;
          state_nxt = S_FIN;
        end
      end
      S_ROOT_TAKE: begin
        cmd.op    = mpq_pkg::OP_ROOT_TAKE;
        state_nxt = (st.kind == mpq_pkg::KIND_REMOVE) ? S_DN_RD : S_FIN;
      end
      S_DN_RD: begin
        if (st.dn_leaf) begin
          cmd.op    = mpq_pkg::OP_PLACE;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = mpq_pkg::OP_DN_RD;
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (st.dn_less) begin
          cmd.op    = mpq_pkg::OP_DN_MOVE;
          state_nxt = S_DN_RD;
        end else begin
          cmd.op    = mpq_pkg::OP_PLACE;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/mpq_dpath.sv =====
module mpq_dpath #(
  parameter int CAPACITY = 1024,
  parameter int AW       = 10,
  parameter int CNT_W    = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mpq_pkg::cmd_t       cmd,
  output mpq_pkg::stat_t      st,
  input  logic [1:0]          in_kind,
  input  logic signed [31:0]  in_key_in,
  output logic signed [31:0]  out_min_out,
  output logic [CNT_W-1:0]    out_occupancy,
  output logic [1:0]          out_status
);

  localparam int XW = AW + 2;

  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rd0_r, rd1_r;

  logic [CNT_W-1:0]   count_r;
  logic [AW-1:0]      pos_r;
  logic signed [31:0] key_r;
  logic signed [31:0] min_r;
  logic [1:0]         status_r;
  logic [1:0]         kind_r;

  logic signed [31:0] omin_r;
  logic [CNT_W-1:0]   oocc_r;
  logic [1:0]         ostat_r;

  logic [AW-1:0]      parent;
  logic [AW:0]        child_l, child_h;
  logic [AW-1:0]      last_idx;
  logic               has_right, sel_right;
  logic signed [31:0] sel_val;
  logic [AW-1:0]      sel_idx;
  logic               full, empty;

  logic               we;
  logic [AW-1:0]      wa, ra0, ra1;
  logic signed [31:0] wd;

  assign parent    = AW'(pos_r - 1'b1) >> 1;
  assign child_l   = {pos_r, 1'b1};
  assign child_h   = child_l + 1'b1;
  assign last_idx  = AW'(count_r - 1'b1);
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign has_right = XW'(child_h) < XW'(count_r);
  assign sel_right = has_right && (rd1_r < rd0_r);
  assign sel_val   = sel_right ? rd1_r : rd0_r;
  assign sel_idx   = sel_right ? child_h[AW-1:0] : child_l[AW-1:0];

  assign st.kind    = kind_r;
  assign st.fail    = (status_r != mpq_pkg::ST_OK);
  assign st.at_root = (pos_r == '0);
  assign st.up_less = (key_r < rd0_r);
  assign st.dn_leaf = XW'(child_l) >= XW'(count_r);
  assign st.dn_less = (sel_val < key_r);

  // memory port steering
  always_comb begin
    we  = 1'b0;
    wa  = pos_r;
    wd  = key_r;
    ra0 = parent;
    ra1 = last_idx;
    case (cmd.op)
      mpq_pkg::OP_UP_MOVE: begin
        we = 1'b1;
        wd = rd0_r;
      end
      mpq_pkg::OP_PLACE: begin
        we = 1'b1;
      end
      mpq_pkg::OP_ROOT_RD: begin
        ra0 = '0;
      end
      mpq_pkg::OP_DN_RD: begin
        ra0 = child_l[AW-1:0];
        ra1 = child_h[AW-1:0];
      end
      mpq_pkg::OP_DN_MOVE: begin
        we = 1'b1;
        wd = sel_val;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd0_r <= mem[ra0];
    rd1_r <= mem[ra1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      case (cmd.op)
        mpq_pkg::OP_ACCEPT: begin
          if (in_kind == mpq_pkg::KIND_INSERT && !full) begin
            count_r <= count_r + 1'b1;
          end
        end
        mpq_pkg::OP_ROOT_TAKE: begin
          if (kind_r == mpq_pkg::KIND_REMOVE) begin
            count_r <= count_r - 1'b1;
          end
        end
        default: begin
          count_r <= count_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      mpq_pkg::OP_ACCEPT: begin
        kind_r   <= in_kind;
        key_r    <= in_key_in;
        min_r    <= '0;
        pos_r    <= count_r[AW-1:0];
        if (in_kind == mpq_pkg::KIND_INSERT && full) begin
          status_r <= mpq_pkg::ST_FULL;
        end else if ((in_kind inside {mpq_pkg::KIND_REMOVE, mpq_pkg::KIND_READ})
                     && empty) begin
          status_r <= mpq_pkg::ST_EMPTY;
        end else begin
          status_r <= mpq_pkg::ST_OK;
        end
      end
      mpq_pkg::OP_UP_MOVE: begin
        pos_r <= parent;
      end
      mpq_pkg::OP_ROOT_TAKE: begin
        min_r <= rd0_r;
        if (kind_r == mpq_pkg::KIND_REMOVE) begin
          // last entry fills the hole at the root
          key_r <= rd1_r;
          pos_r <= '0;
        end
      end
      mpq_pkg::OP_DN_MOVE: begin
        pos_r <= sel_idx;
      end
      default: begin
        pos_r <= pos_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      omin_r  <= min_r;
      oocc_r  <= count_r;
      ostat_r <= status_r;
    end
  end

  assign out_min_out   = omin_r;
  assign out_occupancy = oocc_r;
  assign out_status    = ostat_r;

endmodule

// ===== design/min_priority_queue_unit.sv =====
// Bounded min-priority queue of signed 32-bit keys kept as a binary heap in a single
// memory of CAPACITY entries (one write port, two registered read ports). Each input
// beat is an insert, a remove-minimum or a read-minimum request and gives exactly one
// result beat with the minimum (zero for an insert, a flagged or an unknown request),
// the entry count after the request and a status (empty queue or full store are
// flagged; the request then changes nothing). One request is worked at a time. A read
// only reads the root; an insert climbs from the new last slot toward the root and a
// remove moves the last entry to the root and sinks it, each stopping at the root, at a
// leaf or where heap order holds; a flagged or unknown request goes straight to the result.
// The longest request is a remove that sinks to the bottom; each heap level costs one
// registered memory read and one compare-and-write. The input is ready again in the
// cycle after the result is loaded, so the next request is taken while the last result
// waits in the output register; a result still waiting there holds the following one
// in its finishing state until the output beat is taken.
module min_priority_queue_unit #(
  parameter int CAPACITY = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_kind,
  input  logic signed [31:0]                   in_key_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [31:0]                   out_min_out,
  output logic [$clog2(CAPACITY+1)-1:0]        out_occupancy,
  output logic [1:0]                           out_status
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  mpq_pkg::cmd_t  cmd;
  mpq_pkg::stat_t st;

  mpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  mpq_dpath #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CNT_W    (CNT_W)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_kind       (in_kind),
    .in_key_in     (in_key_in),
    .out_min_out   (out_min_out),
    .out_occupancy (out_occupancy),
    .out_status    (out_status)
  );

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_occupancy <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == mpq_pkg::ST_FULL |-> out_occupancy == CNT_W'(CAPACITY))
    else $error("full status with store not full");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == mpq_pkg::ST_EMPTY |-> out_min_out == '0 && out_occupancy == '0)
    else $error("empty status with nonzero minimum or count");
`endif

endmodule
